FILE: rtl/cigar_coverage_marker_macros.svh
// Assertion macros shared by the coverage marker checkers.
// Expect signals named clk and rst_n in the scope of use.
`ifndef CIGAR_COVERAGE_MARKER_MACROS_SVH
`define CIGAR_COVERAGE_MARKER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CCM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("coverage marker check failed");

// Consequent checked in the cycle after the antecedent.
`define CCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("coverage marker check failed");

`endif

FILE: rtl/ccm_pkg.sv
// Shared types and constants for the CIGAR coverage marker.
// No dependencies.
package ccm_pkg;

  localparam int MAX_GENE_BASES = 65536;
  localparam int WORD_BITS      = 64;
  localparam int BITMAP_WORDS   = (MAX_GENE_BASES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W         = $clog2(BITMAP_WORDS);
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int CNT_W          = BIT_W + 1;
  localparam int POS_W          = 17;
  localparam int LEN_W          = 28;
  localparam int HIT_W          = 32;

  localparam logic [POS_W-1:0] MAX_LIMIT       = POS_W'(MAX_GENE_BASES);
  localparam logic [POS_W-1:0] GENE_LEN_RESET  = POS_W'(65536);

  // action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_OP    = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // CIGAR op codes
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_EQ = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_I  = 4'd5;
  localparam logic [3:0] OP_H  = 4'd6;
  localparam logic [3:0] OP_P  = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  typedef struct packed {
    logic [1:0]       action;
    logic [POS_W-1:0] start_pos;
    logic [3:0]       op_code;
    logic [LEN_W-1:0] op_length;
  } ccm_in_t;

  typedef struct packed {
    logic [POS_W-1:0] covered_bases;
    logic [HIT_W-1:0] alignment_hits;
    logic [POS_W-1:0] ref_position;
  } ccm_out_t;

  // word command from the controller to the bitmap
  typedef struct packed {
    logic                 vld;
    logic                 clr;
    logic [WIDX_W-1:0]    addr;
    logic [WORD_BITS-1:0] mask;
  } ccm_cmd_t;

  // newly covered bits of the word written back
  typedef struct packed {
    logic             add_vld;
    logic [CNT_W-1:0] add_cnt;
  } ccm_resp_t;

endpackage

FILE: rtl/cigar_coverage_marker.sv
// Items are taken in ST_IDLE. Start, skip and no-op items go straight to ST_FIN; marking
// walks the spanned words in ST_MARK, then ST_DRAIN; a clear sweeps one bitmap word a cycle
// in ST_CLEAR. ST_FIN registers the result; a new item is taken only after that, and a
// stalled result holds back the next.
// Reset (synchronous, rst_n low): counters and position zero, gene length 65536,
// then a clearing sweep of the bitmap with in_stall high.
module cigar_coverage_marker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ccm_pkg::ccm_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ccm_pkg::ccm_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ccm_pkg::POS_W-1:0] cfg_data
);

  ccm_pkg::ccm_cmd_t  cmd;
  ccm_pkg::ccm_resp_t resp;

  ccm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .resp      (resp)
  );

  ccm_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .resp  (resp)
  );

endmodule

FILE: rtl/ccm_bitmap.sv
// Coverage bitmap memory with read-modify-write marking and popcount.
// Depends on ccm_pkg.
module ccm_bitmap (
  input  logic               clk,
  input  logic               rst_n,
  input  ccm_pkg::ccm_cmd_t  cmd,
  output ccm_pkg::ccm_resp_t resp
);

  logic [ccm_pkg::WORD_BITS-1:0] mem [ccm_pkg::BITMAP_WORDS];
  logic [ccm_pkg::WORD_BITS-1:0] rdata_r;
  logic [ccm_pkg::WORD_BITS-1:0] mask_r;
  logic [ccm_pkg::WIDX_W-1:0]    addr_r;
  logic                          pend_r;

  function automatic logic [ccm_pkg::CNT_W-1:0] popcount(
    input logic [ccm_pkg::WORD_BITS-1:0] v
  );
    logic [ccm_pkg::CNT_W-1:0] part [ccm_pkg::WORD_BITS];
    for (int i = 0; i < ccm_pkg::WORD_BITS; i++) begin
      part[i] = ccm_pkg::CNT_W'(v[i]);
    end
    // pairwise adder tree, log2 of the word width deep
    for (int s = 1; s < ccm_pkg::WORD_BITS; s = s * 2) begin
      for (int i = 0; i + s < ccm_pkg::WORD_BITS; i = i + 2 * s) begin
        part[i] = part[i] + part[i + s];
      end
    end
    return part[0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.vld & ~cmd.clr;
    end
  end

  // Words of one operation are distinct and operations never overlap,
  // so the write-back never meets a read of the same word.
  always_ff @(posedge clk) begin
    addr_r <= cmd.addr;
    mask_r <= cmd.mask;
    if (cmd.vld) begin
      rdata_r <= mem[cmd.addr];
    end
    if (cmd.vld && cmd.clr) begin
      mem[cmd.addr] <= '0;
    end else if (pend_r) begin
      mem[addr_r] <= rdata_r | mask_r;
    end
  end

  assign resp.add_vld = pend_r;
  assign resp.add_cnt = popcount(mask_r & ~rdata_r);

endmodule

FILE: rtl/ccm_ctrl.sv
// Sequencer for the coverage marker: position, counters, word walk,
// clearing sweep, configuration register and result register.
// Depends on ccm_pkg.
module ccm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ccm_pkg::ccm_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ccm_pkg::ccm_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccm_pkg::POS_W-1:0]     cfg_data,
  output ccm_pkg::ccm_cmd_t             cmd,
  input  ccm_pkg::ccm_resp_t            resp
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_DRAIN,
    ST_FIN
  } state_t;

  localparam int SUM_W = ccm_pkg::LEN_W + 1;
  localparam logic [ccm_pkg::WIDX_W-1:0] LAST_WORD = ccm_pkg::WIDX_W'(ccm_pkg::BITMAP_WORDS - 1);

  state_t                        state_r,   state_nxt;
  logic [ccm_pkg::WIDX_W-1:0]    word_r,    word_nxt;
  logic [ccm_pkg::WIDX_W-1:0]    last_r,    last_nxt;
  logic [ccm_pkg::BIT_W-1:0]     lo_r,      lo_nxt;
  logic [ccm_pkg::BIT_W-1:0]     hi_r,      hi_nxt;
  logic                          first_r,   first_nxt;
  logic                          pend_r,    pend_nxt;
  logic [ccm_pkg::POS_W-1:0]     pos_r,     pos_nxt;
  logic [ccm_pkg::POS_W-1:0]     covered_r, covered_nxt;
  logic [ccm_pkg::HIT_W-1:0]     hits_r,    hits_nxt;
  logic [ccm_pkg::POS_W-1:0]     gene_r,    gene_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ccm_pkg::ccm_out_t             out_data_r,  out_data_nxt;

  logic [ccm_pkg::POS_W-1:0]     limit;
  logic [ccm_pkg::POS_W-1:0]     start_m1;
  logic [ccm_pkg::POS_W-1:0]     cur;
  logic [SUM_W-1:0]              sum;
  logic [ccm_pkg::POS_W-1:0]     end_pos;
  logic [ccm_pkg::POS_W-1:0]     end_m1;
  logic                          mark_op;
  logic                          adv_op;
  logic [ccm_pkg::WORD_BITS-1:0] lo_mask;
  logic [ccm_pkg::WORD_BITS-1:0] hi_mask;

  always_comb begin
    limit    = (gene_r > ccm_pkg::MAX_LIMIT) ? ccm_pkg::MAX_LIMIT : gene_r;
    start_m1 = (in_data.start_pos == '0) ? '0 : in_data.start_pos - 1'b1;
    cur      = (pos_r > limit) ? limit : pos_r;
    sum      = SUM_W'(cur) + SUM_W'(in_data.op_length);
    end_pos  = (sum > SUM_W'(limit)) ? limit : sum[ccm_pkg::POS_W-1:0];
    end_m1   = end_pos - 1'b1;
    mark_op  = in_data.op_code inside {ccm_pkg::OP_M, ccm_pkg::OP_EQ, ccm_pkg::OP_X};
    adv_op   = in_data.op_code inside {ccm_pkg::OP_D, ccm_pkg::OP_N};
    lo_mask  = first_r ? ({ccm_pkg::WORD_BITS{1'b1}} << lo_r) : '1;
    hi_mask  = (word_r == last_r)
             ? ({ccm_pkg::WORD_BITS{1'b1}} >> (ccm_pkg::BIT_W'(ccm_pkg::WORD_BITS - 1) - hi_r))
             : '1;
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    first_nxt     = first_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    covered_nxt   = covered_r;
    hits_nxt      = hits_r;
    gene_nxt      = cfg_valid ? cfg_data : gene_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    cmd           = '0;

    if (resp.add_vld) begin
      covered_nxt = covered_r + ccm_pkg::POS_W'(resp.add_cnt);
    end

    case (state_r)
      ST_CLEAR: begin
        cmd.vld  = 1'b1;
        cmd.clr  = 1'b1;
        cmd.addr = word_r;
        if (word_r == LAST_WORD) begin
          state_nxt = pend_r ? ST_FIN : ST_IDLE;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FIN;
          case (in_data.action)
            ccm_pkg::ACT_START: begin
              pos_nxt  = (start_m1 > limit) ? limit : start_m1;
              hits_nxt = (hits_r == '1) ? hits_r : hits_r + 1'b1;
            end
            ccm_pkg::ACT_OP: begin
              if (mark_op || adv_op) begin
                pos_nxt = end_pos;
              end
              if (mark_op && (end_pos > cur)) begin
                word_nxt  = cur[ccm_pkg::WIDX_W+ccm_pkg::BIT_W-1:ccm_pkg::BIT_W];
                last_nxt  = end_m1[ccm_pkg::WIDX_W+ccm_pkg::BIT_W-1:ccm_pkg::BIT_W];
                lo_nxt    = cur[ccm_pkg::BIT_W-1:0];
                hi_nxt    = end_m1[ccm_pkg::BIT_W-1:0];
                first_nxt = 1'b1;
                state_nxt = ST_MARK;
              end
            end
            ccm_pkg::ACT_CLEAR: begin
              covered_nxt = '0;
              hits_nxt    = '0;
              word_nxt    = '0;
              pend_nxt    = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MARK: begin
        cmd.vld   = 1'b1;
        cmd.addr  = word_r;
        cmd.mask  = lo_mask & hi_mask;
        first_nxt = 1'b0;
        if (word_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last write-back and its count land here
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.covered_bases  = covered_r;
          out_data_nxt.alignment_hits = hits_r;
          out_data_nxt.ref_position   = pos_r;
          pend_nxt                    = 1'b0;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      word_r      <= '0;
      pend_r      <= 1'b0;
      pos_r       <= '0;
      covered_r   <= '0;
      hits_r      <= '0;
      gene_r      <= ccm_pkg::GENE_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      last_r      <= last_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      first_r     <= first_nxt;
      pend_r      <= pend_nxt;
      pos_r       <= pos_nxt;
      covered_r   <= covered_nxt;
      hits_r      <= hits_nxt;
      gene_r      <= gene_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

FILE: rtl/ccm_checker.sv
// Port-level checks for cigar_coverage_marker, attached by bind.
// Depends on ccm_pkg and cigar_coverage_marker_macros.svh.
`include "cigar_coverage_marker_macros.svh"

module ccm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ccm_pkg::ccm_out_t out_data
);

  // a stalled result holds
  `CCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one item at a time: after an input transfer the block stalls
  `CCM_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

  // position never exceeds the largest gene
  `CCM_ASSERT_SAME(a_pos_bound, out_valid, out_data.ref_position <= ccm_pkg::MAX_LIMIT)

  // covered count never exceeds the bitmap size
  `CCM_ASSERT_SAME(a_cov_bound, out_valid, out_data.covered_bases <= ccm_pkg::MAX_LIMIT)

endmodule

bind cigar_coverage_marker ccm_checker u_ccm_checker (.*);

FILE: sim/cigar_coverage_marker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cigar_coverage_marker: directed CIGAR cases, then random
// alignments and noise under several gene lengths, checked against a coverage predictor.
// Depends on ccm_pkg and the cigar_coverage_marker RTL.
module cigar_coverage_marker_tb;
  import ccm_pkg::*;

  localparam int IDLE_LIMIT = 8000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
  localparam int RX_FREE = 0;
  localparam int RX_SPARSE = 1;
  localparam int RX_BURSTY = 2;

  class coverage_predictor;
    bit [WORD_BITS-1:0] map_words [BITMAP_WORDS];
    logic [POS_W-1:0] gene_len;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] covered;
    logic [HIT_W-1:0] hits;
    int mismatches;
    ccm_out_t expected_reports [$];

    function new();
      foreach (map_words[i]) map_words[i] = '0;
      gene_len = GENE_LEN_RESET;
      position = '0;
      covered = '0;
      hits = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_item(ccm_in_t it);
      logic [POS_W-1:0] lim;
      logic [POS_W-1:0] p;
      logic [31:0] stop;
      ccm_out_t res;
      lim = (gene_len > MAX_LIMIT) ? MAX_LIMIT : gene_len;
      case (it.action)
        ACT_START: begin
          p = (it.start_pos == '0) ? '0 : it.start_pos - 1'b1;
          position = (p > lim) ? lim : p;
          if (hits != '1) hits++;
        end
        ACT_OP: begin
          // a position left beyond a shrunken gene is pulled back first
          p = (position > lim) ? lim : position;
          stop = 32'(p) + 32'(it.op_length);
          if (stop > 32'(lim)) stop = 32'(lim);
          case (it.op_code)
            OP_M, OP_EQ, OP_X: begin
              for (int unsigned b = p; b < stop; b++) begin
                if (!map_words[b / WORD_BITS][b % WORD_BITS]) begin
                  map_words[b / WORD_BITS][b % WORD_BITS] = 1'b1;
                  covered++;
                end
              end
              position = stop[POS_W-1:0];
            end
            OP_D, OP_N: position = stop[POS_W-1:0];
            default: ;
          endcase
        end
        ACT_CLEAR: begin
          // position survives a clear
          foreach (map_words[i]) map_words[i] = '0;
          covered = '0;
          hits = '0;
        end
        default: ;
      endcase
      res.covered_bases = covered;
      res.alignment_hits = hits;
      res.ref_position = position;
      expected_reports.push_back(res);
    endfunction

    function void check_report(ccm_out_t got);
      ccm_out_t want;
      if (expected_reports.size() == 0) begin
        $error("unexpected result: covered_bases %0d alignment_hits %0d ref_position %0d",
               got.covered_bases, got.alignment_hits, got.ref_position);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.covered_bases !== want.covered_bases) begin
        $error("covered_bases: expected %0d, actual %0d", want.covered_bases,
               got.covered_bases);
        mismatches++;
      end
      if (got.alignment_hits !== want.alignment_hits) begin
        $error("alignment_hits: expected %0d, actual %0d", want.alignment_hits,
               got.alignment_hits);
        mismatches++;
      end
      if (got.ref_position !== want.ref_position) begin
        $error("ref_position: expected %0d, actual %0d", want.ref_position,
               got.ref_position);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ccm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ccm_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [POS_W-1:0] cfg_data = '0;

  coverage_predictor tracker;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_mode = RX_FREE;
  int rx_mode_left = 0;
  int rx_hold = 0;

  cigar_coverage_marker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: free-running, sparse stalls, or long on/off runs
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(RX_FREE, RX_BURSTY);
      rx_mode_left <= $urandom_range(40, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_FREE: out_stall <= 1'b0;
      RX_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (rx_hold == 0) begin
          out_stall <= !out_stall;
          rx_hold <= $urandom_range(1, 10);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_report(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic ccm_in_t make_item(logic [1:0] action, logic [POS_W-1:0] start,
                                        logic [3:0] code, logic [LEN_W-1:0] len);
    ccm_in_t it;
    it.action = action;
    it.start_pos = start;
    it.op_code = code;
    it.op_length = len;
    return it;
  endfunction

  // sender works in bursts; valid is left high after a transfer, so the caller
  // must present the next item or drop valid at the following falling edge
  task automatic send_item(ccm_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_item(it);
    items_sent++;
  endtask

  task automatic write_gene_length(logic [POS_W-1:0] len);
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    tracker.gene_len = len;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // one read: a start, then a short CIGAR string with random content
  task automatic send_alignment();
    int unsigned lim;
    int nops;
    int r;
    logic [POS_W-1:0] sp;
    logic [3:0] code;
    logic [LEN_W-1:0] len;
    lim = (tracker.gene_len > MAX_LIMIT) ? MAX_LIMIT : tracker.gene_len;
    if ($urandom_range(0, 9) == 0) sp = POS_W'($urandom_range(0, 131071));
    else sp = POS_W'($urandom_range(1, lim + 1));
    send_item(make_item(ACT_START, sp, 4'($urandom_range(0, 15)), LEN_W'($urandom)));
    nops = $urandom_range(1, 6);
    for (int k = 0; k < nops; k++) begin
      case ($urandom_range(0, 10))
        0, 1, 2: code = OP_M;
        3: code = OP_EQ;
        4: code = OP_X;
        5: code = OP_D;
        6: code = OP_N;
        7: code = OP_S;
        8: code = OP_I;
        9: code = OP_H;
        default: code = OP_P;
      endcase
      r = $urandom_range(0, 19);
      if (r < 16) len = LEN_W'($urandom_range(1, 100));
      else if (r < 19) len = LEN_W'($urandom_range(0, 800));
      else len = LEN_W'($urandom);
      send_item(make_item(ACT_OP, POS_W'($urandom), code, len));
    end
  endtask

  initial begin
    int goal;
    int r;
    logic [POS_W-1:0] glen;
    tracker = new();
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // every CIGAR op against the reset gene length
    send_item(make_item(ACT_START, 17'd1, OP_M, 28'd0));
    send_item(make_item(ACT_OP, 17'd0, OP_M, 28'd10));
    send_item(make_item(ACT_OP, 17'd0, OP_EQ, 28'd5));
    send_item(make_item(ACT_OP, 17'd0, OP_X, 28'd3));
    send_item(make_item(ACT_OP, 17'd0, OP_D, 28'd2));
    send_item(make_item(ACT_OP, 17'd0, OP_N, 28'd4));
    send_item(make_item(ACT_OP, 17'd0, OP_S, 28'd7));
    send_item(make_item(ACT_OP, 17'd0, OP_I, 28'd1));
    send_item(make_item(ACT_OP, 17'd0, OP_H, 28'd9));
    send_item(make_item(ACT_OP, 17'd0, OP_P, 28'd2));
    send_item(make_item(ACT_OP, 17'd0, OP_UNKNOWN_LO, 28'd100));
    send_item(make_item(ACT_UNUSED, '1, OP_UNKNOWN_HI, '1));
    send_item(make_item(ACT_START, 17'd0, OP_M, 28'd0));
    send_item(make_item(ACT_OP, 17'd0, OP_M, 28'd20));
    // last base of the gene, then overlong marks and starts
    send_item(make_item(ACT_START, 17'd65536, OP_M, 28'd0));
    send_item(make_item(ACT_OP, 17'd0, OP_M, '1));
    send_item(make_item(ACT_START, 17'd131071, OP_M, 28'd0));
    send_item(make_item(ACT_CLEAR, 17'd0, OP_M, 28'd0));
    // zero-length gene marks nothing
    write_gene_length('0);
    send_item(make_item(ACT_START, 17'd100, OP_M, 28'd0));
    send_item(make_item(ACT_OP, 17'd0, OP_M, 28'd50));
    // shrink the gene under a position beyond the new length
    write_gene_length(17'd1000);
    send_item(make_item(ACT_START, 17'd900, OP_M, 28'd0));
    send_item(make_item(ACT_OP, 17'd0, OP_M, 28'd50));
    write_gene_length(17'd100);
    send_item(make_item(ACT_OP, 17'd0, OP_D, 28'd1));
    send_item(make_item(ACT_CLEAR, 17'd0, OP_M, 28'd0));
    // length above the bitmap size: whole map in one op
    write_gene_length('1);
    send_item(make_item(ACT_START, 17'd1, OP_M, 28'd0));
    send_item(make_item(ACT_OP, 17'd0, OP_M, '1));

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: glen = GENE_LEN_RESET;
        1: glen = POS_W'($urandom_range(2, 300));
        2: glen = 17'd1;
        3: glen = '1;
        4: glen = POS_W'($urandom_range(300, 5000));
        5: glen = '0;
        6: glen = POS_W'($urandom_range(1, 131071));
        default: glen = POS_W'($urandom_range(64, 1024));
      endcase
      write_gene_length(glen);
      goal = items_sent + 56;
      while (items_sent < goal) begin
        r = $urandom_range(0, 19);
        if (r < 3) begin
          send_item(make_item(2'($urandom_range(0, 3)), POS_W'($urandom_range(0, 131071)),
                              4'($urandom_range(0, 15)), LEN_W'($urandom)));
        end else if (r == 3) begin
          send_item(make_item(ACT_CLEAR, POS_W'($urandom), 4'($urandom), LEN_W'($urandom)));
        end else begin
          send_alignment();
        end
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/ccm_pkg.sv
rtl/ccm_bitmap.sv
rtl/ccm_ctrl.sv
rtl/cigar_coverage_marker.sv
rtl/ccm_checker.sv
sim/cigar_coverage_marker_tb.sv
